// ===== hdl/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg
// Types, codes and table lookups for the table-driven token lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdl_pkg;

  localparam int TOKEN_W = 16;

  typedef enum logic [2:0] {
    ST_BEGIN,
    ST_COMMENT,
    ST_ERROR,
    ST_IDENT,
    ST_MINUS,
    ST_NUMBER,
    ST_OPER,
    ST_PUNCT
  } scan_state_t;

  typedef enum logic [3:0] {
    C_ALPHA,
    C_DIGIT,
    C_HASH,
    C_ILLEGAL,
    C_MINUS,
    C_NEWLINE,
    C_NULL,
    C_OP,
    C_PUNCT,
    C_UNDER,
    C_WHITE
  } char_class_t;

  typedef enum logic [2:0] {
    KIND_END,
    KIND_ERROR,
    KIND_IDENT,
    KIND_NUMBER,
    KIND_OPER,
    KIND_PUNCT
  } token_kind_t;

  // transition code: msb set means a token ends, low bits are then the kind
  typedef logic [3:0] trans_code_t;

  localparam trans_code_t T_END = {1'b1, KIND_END};
  localparam trans_code_t T_ERR = {1'b1, KIND_ERROR};
  localparam trans_code_t T_ID  = {1'b1, KIND_IDENT};
  localparam trans_code_t T_NUM = {1'b1, KIND_NUMBER};
  localparam trans_code_t T_OP  = {1'b1, KIND_OPER};
  localparam trans_code_t T_PU  = {1'b1, KIND_PUNCT};

  typedef struct packed {
    token_kind_t        kind;
    logic [TOKEN_W-1:0] start;
    logic [TOKEN_W-1:0] stop;
    logic               last;
    logic               sat;
  } token_t;

  function automatic trans_code_t go(input scan_state_t s);
    return {1'b0, s};
  endfunction

  function automatic char_class_t classify(input logic [7:0] b);
    char_class_t c;
    case (b) inside
      [8'h61:8'h7a], [8'h41:8'h5a]: c = C_ALPHA;
      [8'h30:8'h39]:                c = C_DIGIT;
      8'h00:                        c = C_NULL;
      8'h09, 8'h20:                 c = C_WHITE;
      8'h0a:                        c = C_NEWLINE;
      8'h23:                        c = C_HASH;
      8'h2d:                        c = C_MINUS;
      8'h5f:                        c = C_UNDER;
      8'h28, 8'h29, 8'h2c, 8'h2e, 8'h3a, 8'h3b,
      8'h3c, 8'h3e, 8'h5b, 8'h5d, 8'h7b, 8'h7d: c = C_PUNCT;
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2b, 8'h2f,
      8'h3d, 8'h3f, 8'h40, 8'h5e, 8'h7c, 8'h7e: c = C_OP;
      default:                      c = C_ILLEGAL;
    endcase
    return c;
  endfunction

  function automatic trans_code_t next_code(input scan_state_t s, input char_class_t c);
    trans_code_t t;
    case (s)
      ST_BEGIN: begin
        case (c)
          C_ALPHA:   t = go(ST_IDENT);
          C_DIGIT:   t = go(ST_NUMBER);
          C_HASH:    t = go(ST_COMMENT);
          C_MINUS:   t = go(ST_MINUS);
          C_NEWLINE: t = go(ST_BEGIN);
          C_NULL:    t = T_END;
          C_OP:      t = go(ST_OPER);
          C_PUNCT:   t = go(ST_PUNCT);
          C_WHITE:   t = go(ST_BEGIN);
          default:   t = go(ST_ERROR);
        endcase
      end
      ST_COMMENT: begin
        case (c)
          C_NEWLINE: t = go(ST_BEGIN);
          C_NULL:    t = T_END;
          default:   t = go(ST_COMMENT);
        endcase
      end
      ST_IDENT: begin
        case (c) inside
          C_ALPHA, C_DIGIT, C_UNDER: t = go(ST_IDENT);
          default:                   t = T_ID;
        endcase
      end
      ST_MINUS: begin
        case (c) inside
          C_DIGIT:      t = go(ST_NUMBER);
          C_MINUS, C_OP: t = go(ST_OPER);
          default:      t = T_OP;
        endcase
      end
      ST_NUMBER: t = (c == C_DIGIT) ? go(ST_NUMBER) : T_NUM;
      ST_OPER: begin
        case (c) inside
          C_MINUS, C_OP: t = go(ST_OPER);
          default:       t = T_OP;
        endcase
      end
      ST_PUNCT: t = T_PU;
      default:  t = T_ERR;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tdl_step.sv =====
// ----------------------------------------------------------------------------
// tdl_step
// One lexer step: classifies a byte, walks the transition table with rescan
// of a terminating byte, and produces up to two tokens and the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_step #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic [7:0]             source_byte,
  input  wire tdl_pkg::scan_state_t   scan_state,
  input  wire logic [OFFSET_BITS-1:0] byte_offset,
  input  wire logic [OFFSET_BITS-1:0] token_begin,
  input  wire logic                   saturated_flag,
  output tdl_pkg::scan_state_t        scan_state_next,
  output logic      [OFFSET_BITS-1:0] byte_offset_next,
  output logic      [OFFSET_BITS-1:0] token_begin_next,
  output logic                        saturated_flag_next,
  output logic      [1:0]             res_count,
  output tdl_pkg::token_t             res0,
  output tdl_pkg::token_t             res1
);
  import tdl_pkg::*;

  char_class_t            cls;
  trans_code_t            nx;
  trans_code_t            again;
  logic [OFFSET_BITS-1:0] off_adv;
  logic                   sat_adv;
  logic [TOKEN_W-1:0]     o16;
  logic [TOKEN_W-1:0]     tb16;
  token_t                 end_tok;

  assign cls   = classify(source_byte);
  assign nx    = next_code(scan_state, cls);
  assign again = next_code(ST_BEGIN, cls);
  assign o16   = TOKEN_W'(byte_offset);
  assign tb16  = TOKEN_W'(token_begin);

  // saturating offset advance
  always_comb begin
    if (byte_offset == '1) begin
      off_adv = byte_offset;
      sat_adv = 1'b1;
    end else begin
      off_adv = byte_offset + OFFSET_BITS'(1);
      sat_adv = saturated_flag;
    end
  end

  always_comb begin
    end_tok = '{kind: KIND_END, start: o16, stop: o16, last: 1'b1, sat: saturated_flag};
  end

  always_comb begin
    scan_state_next     = scan_state;
    byte_offset_next    = off_adv;
    token_begin_next    = token_begin;
    saturated_flag_next = sat_adv;
    res_count           = 2'd0;
    res0                = end_tok;
    res1                = end_tok;
    if (!nx[3]) begin
      scan_state_next = scan_state_t'(nx[2:0]);
      if (scan_state == ST_BEGIN) begin
        token_begin_next = byte_offset;
      end
    end else if (nx == T_END) begin
      scan_state_next     = ST_BEGIN;
      byte_offset_next    = '0;
      token_begin_next    = '0;
      saturated_flag_next = 1'b0;
      res_count           = 2'd1;
    end else begin
      res0 = '{kind: token_kind_t'(nx[2:0]), start: tb16, stop: o16, last: 1'b1,
               sat: saturated_flag};
      if (again == T_END) begin
        res0.last           = 1'b0;
        scan_state_next     = ST_BEGIN;
        byte_offset_next    = '0;
        token_begin_next    = '0;
        saturated_flag_next = 1'b0;
        res_count           = 2'd2;
      end else begin
        scan_state_next  = scan_state_t'(again[2:0]);
        token_begin_next = byte_offset;
        res_count        = 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/table_driven_token_lexer.sv =====
// ----------------------------------------------------------------------------
// table_driven_token_lexer
// Byte-at-a-time lexer: character classes, eight-state transition table,
// token kind with start and stop offsets, buffered on a valid/ready output.
//
//   channel   direction  word
//   in        sink       source_byte
//   out       source     token_kind, token_start, token_stop, run_last,
//                        offset_saturated
//
// one byte per cycle while in_ready is high; lexer state updates in the accept cycle
// a byte gives zero, one or two tokens into a four-entry output queue
// in_ready is high while the queue has room for two tokens
// a NUL ending a token also pushes the end token, so the queue has one more token to drain
// reset empties the queue and returns the lexer to offset 0, begin state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_driven_token_lexer #(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   source_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tdl_pkg::token_kind_t              token_kind,
  output logic      [tdl_pkg::TOKEN_W-1:0]  token_start,
  output logic      [tdl_pkg::TOKEN_W-1:0]  token_stop,
  output logic                              run_last,
  output logic                              offset_saturated
);
  import tdl_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  scan_state_t            scan_state, scan_state_next;
  logic [OFFSET_BITS-1:0] byte_offset, byte_offset_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next;
  logic                   saturated_flag, saturated_flag_next;
  logic [1:0]             res_count;
  token_t                 res0, res1;

  token_t                 queue [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr, rd_ptr;
  logic [QPTR_W:0]        count, count_next;
  logic                   accept, pop;
  logic [1:0]             push;
  token_t                 head;

  tdl_step #(.OFFSET_BITS(OFFSET_BITS)) u_step (
    .source_byte         (source_byte),
    .scan_state          (scan_state),
    .byte_offset         (byte_offset),
    .token_begin         (token_begin),
    .saturated_flag      (saturated_flag),
    .scan_state_next     (scan_state_next),
    .byte_offset_next    (byte_offset_next),
    .token_begin_next    (token_begin_next),
    .saturated_flag_next (saturated_flag_next),
    .res_count           (res_count),
    .res0                (res0),
    .res1                (res1)
  );

  assign in_ready   = (count <= (QPTR_W+1)'(QDEPTH - 2));
  assign accept     = in_valid & in_ready;
  assign out_valid  = (count != '0);
  assign pop        = out_valid & out_ready;
  assign push       = accept ? res_count : 2'd0;
  assign count_next = count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state     <= ST_BEGIN;
      byte_offset    <= '0;
      token_begin    <= '0;
      saturated_flag <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        scan_state     <= scan_state_next;
        byte_offset    <= byte_offset_next;
        token_begin    <= token_begin_next;
        saturated_flag <= saturated_flag_next;
      end
      wr_ptr <= wr_ptr + QPTR_W'(push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (push == 2'd2) begin
      queue[wr_ptr + QPTR_W'(1)] <= res1;
    end
  end

  assign head             = queue[rd_ptr];
  assign token_kind       = head.kind;
  assign token_start      = head.start;
  assign token_stop       = head.stop;
  assign run_last         = head.last;
  assign offset_saturated = head.sat;

endmodule

`default_nettype wire

// ===== hdl/tdl_check.sv =====
// ----------------------------------------------------------------------------
// tdl_check
// Port-level checks on the token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdl_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [7:0]                  source_byte,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire tdl_pkg::token_kind_t        token_kind,
  input wire logic [tdl_pkg::TOKEN_W-1:0] token_start,
  input wire logic [tdl_pkg::TOKEN_W-1:0] token_stop,
  input wire logic                        run_last,
  input wire logic                        offset_saturated
);
  import tdl_pkg::*;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // end of source always yields a token
  a_nul_emits: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && source_byte == 8'h00 |=> out_valid)
    else $error("no token after end of source");

  // end token is the last of its byte and has zero length
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_END |-> run_last && token_start == token_stop)
    else $error("malformed end token");

  // a stalled token holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_start)
      && $stable(token_stop) && $stable(run_last) && $stable(offset_saturated))
    else $error("stalled token changed");

endmodule

bind table_driven_token_lexer tdl_check u_tdl_check (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .source_byte      (source_byte),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .token_kind       (token_kind),
  .token_start      (token_start),
  .token_stop       (token_stop),
  .run_last         (run_last),
  .offset_saturated (offset_saturated)
);

`default_nettype wire
